### hdl/rrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants for the random-removal shuffle block.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int DATA_W       = 32;
  localparam int DRAW_W       = 16;
  localparam int REMAIN_W     = 5;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED = 2'd0,
    ST_POPPED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_READ,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic div_step;
    logic pop_commit;
    logic finish;
  } rrs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_go;
    logic div_last;
    logic out_free;
  } rrs_sts_t;

endpackage

### hdl/rrs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_in_if / rrs_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface rrs_in_if;
  import rrs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [DATA_W-1:0] item_value;
  logic [DRAW_W-1:0]        random_number;

  modport source (output valid, output opcode, output item_value,
                  output random_number, input ready);
  modport sink   (input valid, input opcode, input item_value,
                  input random_number, output ready);
endinterface

interface rrs_out_if;
  import rrs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic [STATUS_W-1:0]      status;
  logic [REMAIN_W-1:0]      remaining;

  modport source (output valid, output popped_value, output status,
                  output remaining, input ready);
  modport sink   (input valid, input popped_value, input status,
                  input remaining, output ready);
endinterface

### hdl/rrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_ctrl
// Sequencer: accept, bit-serial remainder, read and close gap, emit result.
// ----------------------------------------------------------------------------
module rrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrs_pkg::rrs_sts_t sts,
  output rrs_pkg::rrs_cmd_t cmd
);
  import rrs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // no beat is taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.pop_go ? S_DIVIDE : S_FINISH;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.pop_commit = 1'b1;
        state_nxt      = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/rrs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_dp
// Entry list, count, remainder unit and result register.
// ----------------------------------------------------------------------------
module rrs_dp #(
  parameter int CAPACITY = rrs_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_opcode,
  input  logic signed [rrs_pkg::DATA_W-1:0] in_item_value,
  input  logic [rrs_pkg::DRAW_W-1:0]       in_random_number,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [rrs_pkg::DATA_W-1:0] out_popped_value,
  output logic [rrs_pkg::STATUS_W-1:0]     out_status,
  output logic [rrs_pkg::REMAIN_W-1:0]     out_remaining,
  input  rrs_pkg::rrs_cmd_t                cmd,
  output rrs_pkg::rrs_sts_t                sts
);
  import rrs_pkg::*;

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int BCW = $clog2(DRAW_W);

  logic [DATA_W-1:0]   ent_r [CAPACITY];
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                op_r;
  logic                pop_ok_r;
  logic [DATA_W-1:0]   item_r;
  logic [DRAW_W-1:0]   draw_r;
  logic [CW-1:0]       rem_r;
  logic [CW-1:0]       rem_nxt;
  logic [BCW-1:0]      bit_cnt_r;
  logic [DATA_W-1:0]   got_r;
  logic [CW:0]         trial;
  logic [IW-1:0]       idx;
  logic                full;
  logic                do_load;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_value_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [REMAIN_W-1:0] out_remain_r;
  logic [31:0]         count_wide;

  assign full    = (count_r == CW'(CAPACITY));
  assign do_load = cmd.finish && (op_r == OP_LOAD) && !full;
  assign idx     = rem_r[IW-1:0];

  // one restoring step per draw bit, msb first
  always_comb begin
    trial = {rem_r, draw_r[DRAW_W-1]};
    if (trial >= {1'b0, count_r}) begin
      rem_nxt = CW'(trial - {1'b0, count_r});
    end else begin
      rem_nxt = CW'(trial);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_load) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop_commit) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign count_wide = 32'(count_nxt);

  assign sts.pop_go   = (in_opcode == OP_POP) && (count_r != '0);
  assign sts.div_last = (bit_cnt_r == BCW'(DRAW_W - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_opcode;
      pop_ok_r  <= sts.pop_go;
      item_r    <= in_item_value;
      draw_r    <= in_random_number;
      rem_r     <= '0;
      bit_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      draw_r    <= {draw_r[DRAW_W-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r + BCW'(1);
    end
  end

  // read the chosen entry and shift the later ones down in the same beat
  always_ff @(posedge clk) begin
    if (cmd.pop_commit) begin
      got_r <= ent_r[idx];
      for (int k = 0; k < CAPACITY - 1; k++) begin
        if (k >= int'(idx)) begin
          ent_r[k] <= ent_r[k + 1];
        end
      end
    end
    if (do_load) begin
      ent_r[count_r[IW-1:0]] <= item_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_remain_r <= count_wide[REMAIN_W-1:0];
      if (op_r == OP_LOAD) begin
        out_value_r  <= '0;
        out_status_r <= full ? ST_FULL : ST_LOADED;
      end else if (pop_ok_r) begin
        out_value_r  <= got_r;
        out_status_r <= ST_POPPED;
      end else begin
        out_value_r  <= '0;
        out_status_r <= ST_EMPTY;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_remaining    = out_remain_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_commit |-> (rem_r < count_r))
    else $error("pop index not below count");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_commit |=> (count_r == $past(count_r) - CW'(1)))
    else $error("pop did not remove exactly one entry");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("result register not loaded on finish");

endmodule

### hdl/random_removal_shuffle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_removal_shuffle
// Holds up to CAPACITY values; a pop removes the entry at draw mod count and
// closes the gap, so popping all entries gives them in shuffled order.
//
//   channel   dir  handshake      beat contents
//   in_chan   in   valid/ready    opcode, item_value, random_number
//   out_chan  out  valid/ready    popped_value, status, remaining
//
// Load: accept, then result into the output register once it is free.
// Pop: accept, then the bit-serial remainder unit takes 16 steps, one per
//   draw bit, followed by one read-and-shift step, then the result.
// Pop from an empty list goes straight to the result like a load.
// Reset (rst_n low, synchronous) empties the list; no clearing pass.
// A stalled result holds in the output register; the next beat is accepted
//   meanwhile and waits only at its own result.
// ----------------------------------------------------------------------------
module random_removal_shuffle #(
  parameter int CAPACITY = rrs_pkg::CAPACITY_DEF
) (
  input logic  clk,
  input logic  rst_n,
  rrs_in_if.sink    in_chan,
  rrs_out_if.source out_chan
);
  import rrs_pkg::*;

  rrs_cmd_t cmd;
  rrs_sts_t sts;

  rrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrs_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_chan.opcode),
    .in_item_value    (in_chan.item_value),
    .in_random_number (in_chan.random_number),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_popped_value (out_chan.popped_value),
    .out_status       (out_chan.status),
    .out_remaining    (out_chan.remaining),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
